// ----- hdl/lhc_pkg.sv -----
// Shared types and codes for the handle cache.
`timescale 1ns / 1ps
package lhc_pkg;

    localparam int KEY_IN_BITS  = 32;
    localparam int VERSION_BITS = 63;

    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_FLUSH   = 1'b1;

    localparam logic [2:0] STATUS_HIT         = 3'd0;
    localparam logic [2:0] STATUS_INSTALLED   = 3'd1;
    localparam logic [2:0] STATUS_COMPILE_ERR = 3'd2;
    localparam logic [2:0] STATUS_UNCACHED    = 3'd3;
    localparam logic [2:0] STATUS_FLUSHED     = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_REPLY
    } t_state;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] slot;
        logic       evicted;
        logic       stale_dropped;
    } t_result;

    // Memory and valid-bit controls from the sequencer to the store.
    typedef struct packed {
        logic rd_en;
        logic tag_we;
        logic stamp_we;
        logic valid_we;
        logic valid_val;
        logic clear_all;
    } t_mem_ctl;

endpackage

// ----- hdl/lhc_req_if.sv -----
// Request channel: valid/ready with the acquire or flush command.
`timescale 1ns / 1ps
interface lhc_req_if import lhc_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic                    cmd;
    logic [KEY_IN_BITS-1:0]  key;
    logic [VERSION_BITS-1:0] version;
    logic                    reset_ok;
    logic                    compile_ok;

    modport source (output valid, cmd, key, version, reset_ok, compile_ok, input ready);
    modport sink   (input valid, cmd, key, version, reset_ok, compile_ok, output ready);
endinterface

// ----- hdl/lhc_rsp_if.sv -----
// Response channel: valid/ready with the lookup outcome.
`timescale 1ns / 1ps
interface lhc_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [3:0] slot;
    logic       evicted;
    logic       stale_dropped;

    modport source (output valid, status, slot, evicted, stale_dropped, input ready);
    modport sink   (input valid, status, slot, evicted, stale_dropped, output ready);
endinterface

// ----- hdl/lhc_store.sv -----
// Entry storage: tag and stamp memories plus per-entry valid flops.
`timescale 1ns / 1ps
module lhc_store import lhc_pkg::*; #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int STAMP_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_mem_ctl                    i_ctl,
    input  logic [$clog2(ENTRIES)-1:0]  i_rd_idx,
    input  logic [$clog2(ENTRIES)-1:0]  i_wr_idx,
    input  logic [KEY_BITS-1:0]         i_wr_key,
    input  logic [VERSION_BITS-1:0]     i_wr_version,
    input  logic [STAMP_BITS-1:0]       i_wr_stamp,
    output logic [KEY_BITS-1:0]         o_rd_key,
    output logic [VERSION_BITS-1:0]     o_rd_version,
    output logic [STAMP_BITS-1:0]       o_rd_stamp,
    output logic [ENTRIES-1:0]          o_valid
);

    localparam int TAG_W = KEY_BITS + VERSION_BITS;

    logic [TAG_W-1:0]      tag_mem   [ENTRIES];
    logic [STAMP_BITS-1:0] stamp_mem [ENTRIES];
    logic [TAG_W-1:0]      r_rd_tag;
    logic [STAMP_BITS-1:0] r_rd_stamp;
    logic [ENTRIES-1:0]    r_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.tag_we) begin
            tag_mem[i_wr_idx] <= {i_wr_key, i_wr_version};
        end
        if (i_ctl.rd_en) begin
            r_rd_tag <= tag_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.stamp_we) begin
            stamp_mem[i_wr_idx] <= i_wr_stamp;
        end
        if (i_ctl.rd_en) begin
            r_rd_stamp <= stamp_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.clear_all) begin
            r_valid <= '0;
        end else if (i_ctl.valid_we) begin
            r_valid[i_wr_idx] <= i_ctl.valid_val;
        end
    end

    assign o_rd_key     = r_rd_tag[TAG_W-1:VERSION_BITS];
    assign o_rd_version = r_rd_tag[VERSION_BITS-1:0];
    assign o_rd_stamp   = r_rd_stamp;
    assign o_valid      = r_valid;

endmodule

// ----- hdl/lhc_ctrl.sv -----
// Scan sequencer: walks the entries, tracks free/LRU/match, writes back.
`timescale 1ns / 1ps
module lhc_ctrl import lhc_pkg::*; #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int STAMP_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_reuse_enable,
    lhc_req_if.sink                     i_req,
    input  logic                        i_res_ready,
    output logic                        o_res_valid,
    output t_result                     o_res,
    output t_mem_ctl                    o_ctl,
    output logic [$clog2(ENTRIES)-1:0]  o_rd_idx,
    output logic [$clog2(ENTRIES)-1:0]  o_wr_idx,
    output logic [KEY_BITS-1:0]         o_wr_key,
    output logic [VERSION_BITS-1:0]     o_wr_version,
    output logic [STAMP_BITS-1:0]       o_wr_stamp,
    input  logic [KEY_BITS-1:0]         i_rd_key,
    input  logic [VERSION_BITS-1:0]     i_rd_version,
    input  logic [STAMP_BITS-1:0]       i_rd_stamp,
    input  logic [ENTRIES-1:0]          i_valid
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int SLOT_W = (IDX_W < 4) ? IDX_W : 4;
    localparam int KEY_W = (KEY_BITS < KEY_IN_BITS) ? KEY_BITS : KEY_IN_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    t_state r_state, n_state;

    logic                    r_issuing, n_issuing;
    logic [IDX_W-1:0]        r_issue_idx, n_issue_idx;
    logic                    r_chk_vld, n_chk_vld;
    logic [IDX_W-1:0]        r_chk_idx, n_chk_idx;
    logic [KEY_BITS-1:0]     r_key, n_key;
    logic [VERSION_BITS-1:0] r_version, n_version;
    logic                    r_reset_ok, n_reset_ok;
    logic                    r_compile_ok, n_compile_ok;
    logic                    r_free_found, n_free_found;
    logic [IDX_W-1:0]        r_free_idx, n_free_idx;
    logic                    r_lru_found, n_lru_found;
    logic [IDX_W-1:0]        r_lru_idx, n_lru_idx;
    logic [STAMP_BITS-1:0]   r_lru_stamp, n_lru_stamp;
    logic                    r_match, n_match;
    logic                    r_hit, n_hit;
    logic [IDX_W-1:0]        r_match_idx, n_match_idx;
    logic [STAMP_BITS-1:0]   r_use_clock, n_use_clock;
    t_result                 r_res, n_res;

    logic                    accept;
    logic                    chk_entry_valid;
    logic                    ent_match;
    logic                    scan_end;
    logic [IDX_W-1:0]        target_idx;
    logic                    dec_evicted;
    t_result                 dec_res;
    logic [STAMP_BITS-1:0]   next_stamp;
    logic                    commit;

    assign accept          = i_req.valid && i_req.ready;
    assign chk_entry_valid = i_valid[r_chk_idx];
    assign ent_match       = r_chk_vld && chk_entry_valid && (i_rd_key == r_key);
    assign scan_end        = r_chk_vld && (ent_match || (r_chk_idx == LAST_IDX));
    assign next_stamp      = r_use_clock + 1'b1;
    assign commit          = (r_state == S_DECIDE) && i_res_ready;

    // Install target: a dropped match reuses its slot, then a free slot, then LRU.
    always_comb begin
        dec_evicted = 1'b0;
        if (r_match) begin
            target_idx = r_match_idx;
        end else if (r_free_found) begin
            target_idx = r_free_idx;
        end else begin
            target_idx  = r_lru_found ? r_lru_idx : '0;
            dec_evicted = 1'b1;
        end

        dec_res = '0;
        if (r_match && r_hit) begin
            dec_res.status = STATUS_HIT;
            dec_res.slot   = 4'(r_match_idx[SLOT_W-1:0]);
        end else if (!r_compile_ok) begin
            dec_res.status        = STATUS_COMPILE_ERR;
            dec_res.stale_dropped = r_match;
        end else begin
            dec_res.status        = STATUS_INSTALLED;
            dec_res.slot          = 4'(target_idx[SLOT_W-1:0]);
            dec_res.evicted       = dec_evicted;
            dec_res.stale_dropped = r_match;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req.cmd == CMD_FLUSH || !i_reuse_enable) begin
                        n_state = S_REPLY;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_REPLY: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and memory controls
    always_comb begin
        i_req.ready = (r_state == S_IDLE);
        o_res_valid = (r_state == S_DECIDE) || (r_state == S_REPLY);
        o_res       = (r_state == S_DECIDE) ? dec_res : r_res;

        o_ctl           = '0;
        o_ctl.rd_en     = (r_state == S_SCAN) && r_issuing;
        o_ctl.clear_all = accept && (i_req.cmd == CMD_FLUSH);
        o_rd_idx        = r_issue_idx;
        o_wr_idx        = (r_match && r_hit) ? r_match_idx : target_idx;
        o_wr_key        = r_key;
        o_wr_version    = r_version;
        o_wr_stamp      = next_stamp;

        if (commit) begin
            if (r_match && r_hit) begin
                o_ctl.stamp_we = 1'b1;
            end else if (r_compile_ok) begin
                o_ctl.tag_we    = 1'b1;
                o_ctl.stamp_we  = 1'b1;
                o_ctl.valid_we  = 1'b1;
                o_ctl.valid_val = 1'b1;
            end else if (r_match) begin
                o_ctl.valid_we  = 1'b1;
                o_ctl.valid_val = 1'b0;
            end
        end
    end

    // Datapath next values
    always_comb begin
        n_issuing    = r_issuing;
        n_issue_idx  = r_issue_idx;
        n_chk_vld    = r_chk_vld;
        n_chk_idx    = r_chk_idx;
        n_key        = r_key;
        n_version    = r_version;
        n_reset_ok   = r_reset_ok;
        n_compile_ok = r_compile_ok;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_lru_found  = r_lru_found;
        n_lru_idx    = r_lru_idx;
        n_lru_stamp  = r_lru_stamp;
        n_match      = r_match;
        n_hit        = r_hit;
        n_match_idx  = r_match_idx;
        n_use_clock  = r_use_clock;
        n_res        = r_res;

        if (accept) begin
            n_key        = KEY_BITS'(i_req.key[KEY_W-1:0]);
            n_version    = i_req.version;
            n_reset_ok   = i_req.reset_ok;
            n_compile_ok = i_req.compile_ok;
            n_issuing    = 1'b1;
            n_issue_idx  = '0;
            n_chk_vld    = 1'b0;
            n_free_found = 1'b0;
            n_lru_found  = 1'b0;
            n_match      = 1'b0;
            n_hit        = 1'b0;
            n_res        = '0;
            n_res.status = (i_req.cmd == CMD_FLUSH) ? STATUS_FLUSHED : STATUS_UNCACHED;
        end

        if (r_state == S_SCAN) begin
            // read issued this cycle is checked next cycle
            n_chk_vld = r_issuing;
            n_chk_idx = r_issue_idx;
            if (r_issuing) begin
                n_issue_idx = r_issue_idx + 1'b1;
                if (r_issue_idx == LAST_IDX) begin
                    n_issuing = 1'b0;
                end
            end
            if (ent_match) begin
                n_issuing   = 1'b0;
                n_chk_vld   = 1'b0;
                n_match     = 1'b1;
                n_hit       = (i_rd_version == r_version) && r_reset_ok;
                n_match_idx = r_chk_idx;
            end else if (r_chk_vld && !chk_entry_valid) begin
                if (!r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_chk_idx;
                end
            end else if (r_chk_vld) begin
                if (!r_lru_found || (i_rd_stamp < r_lru_stamp)) begin
                    n_lru_found = 1'b1;
                    n_lru_idx   = r_chk_idx;
                    n_lru_stamp = i_rd_stamp;
                end
            end
        end

        if (commit && ((r_match && r_hit) || r_compile_ok)) begin
            n_use_clock = next_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_issuing    <= 1'b0;
            r_chk_vld    <= 1'b0;
            r_use_clock  <= '0;
            r_free_found <= 1'b0;
            r_lru_found  <= 1'b0;
            r_match      <= 1'b0;
            r_hit        <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_issuing    <= n_issuing;
            r_chk_vld    <= n_chk_vld;
            r_use_clock  <= n_use_clock;
            r_free_found <= n_free_found;
            r_lru_found  <= n_lru_found;
            r_match      <= n_match;
            r_hit        <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_issue_idx  <= n_issue_idx;
        r_chk_idx    <= n_chk_idx;
        r_key        <= n_key;
        r_version    <= n_version;
        r_reset_ok   <= n_reset_ok;
        r_compile_ok <= n_compile_ok;
        r_free_idx   <= n_free_idx;
        r_lru_idx    <= n_lru_idx;
        r_lru_stamp  <= n_lru_stamp;
        r_match_idx  <= n_match_idx;
        r_res        <= n_res;
    end

endmodule

// ----- hdl/lru_handle_cache_with_staleness.sv -----
// Acquire, caching on: the idle state takes the request, the scan fills the read pipeline
// and checks one entry per cycle, and the write-back waits for a free response register;
// a scan that stops at a matching key is shorter. Flush and uncached requests skip the scan.
// One request in flight; the response register frees the next request while a response waits.
// Reset (synchronous): valid bits and use clock cleared, reuse enabled; no clearing pass.
`timescale 1ns / 1ps
module lru_handle_cache_with_staleness import lhc_pkg::*; #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int STAMP_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    lhc_req_if.sink   i_req,
    lhc_rsp_if.source o_rsp
);

    localparam int IDX_W = $clog2(ENTRIES);

    logic                    r_reuse_enable;
    logic                    r_rsp_valid, n_rsp_valid;
    t_result                 r_rsp, n_rsp;

    logic                    res_valid;
    logic                    res_ready;
    t_result                 res;
    t_mem_ctl                mem_ctl;
    logic [IDX_W-1:0]        rd_idx;
    logic [IDX_W-1:0]        wr_idx;
    logic [KEY_BITS-1:0]     wr_key;
    logic [VERSION_BITS-1:0] wr_version;
    logic [STAMP_BITS-1:0]   wr_stamp;
    logic [KEY_BITS-1:0]     rd_key;
    logic [VERSION_BITS-1:0] rd_version;
    logic [STAMP_BITS-1:0]   rd_stamp;
    logic [ENTRIES-1:0]      valid_bits;

    lhc_store #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .STAMP_BITS (STAMP_BITS)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (mem_ctl),
        .i_rd_idx     (rd_idx),
        .i_wr_idx     (wr_idx),
        .i_wr_key     (wr_key),
        .i_wr_version (wr_version),
        .i_wr_stamp   (wr_stamp),
        .o_rd_key     (rd_key),
        .o_rd_version (rd_version),
        .o_rd_stamp   (rd_stamp),
        .o_valid      (valid_bits)
    );

    lhc_ctrl #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .STAMP_BITS (STAMP_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_reuse_enable (r_reuse_enable),
        .i_req          (i_req),
        .i_res_ready    (res_ready),
        .o_res_valid    (res_valid),
        .o_res          (res),
        .o_ctl          (mem_ctl),
        .o_rd_idx       (rd_idx),
        .o_wr_idx       (wr_idx),
        .o_wr_key       (wr_key),
        .o_wr_version   (wr_version),
        .o_wr_stamp     (wr_stamp),
        .i_rd_key       (rd_key),
        .i_rd_version   (rd_version),
        .i_rd_stamp     (rd_stamp),
        .i_valid        (valid_bits)
    );

    // Response register: free when empty or being transferred this cycle.
    assign res_ready = !r_rsp_valid || o_rsp.ready;

    always_comb begin
        n_rsp_valid = r_rsp_valid;
        n_rsp       = r_rsp;
        if (res_ready) begin
            n_rsp_valid = res_valid;
            if (res_valid) begin
                n_rsp = res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reuse_enable <= 1'b1;
            r_rsp_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_reuse_enable <= i_cfg_wdata;
            end
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_rsp.valid         = r_rsp_valid;
    assign o_rsp.status        = r_rsp.status;
    assign o_rsp.slot          = r_rsp.slot;
    assign o_rsp.evicted       = r_rsp.evicted;
    assign o_rsp.stale_dropped = r_rsp.stale_dropped;

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the LRU handle cache: shadow table, random traffic, handshake stalls.
`timescale 1ns / 1ps
module testbench import lhc_pkg::*;;

    localparam int N_ENTRIES   = 16;
    localparam int POOL_SIZE   = 24;
    localparam int TAIL_CYCLES = N_ENTRIES + 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [62:0] VERSION_MAX = '1;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    lhc_req_if req_ch ();
    lhc_rsp_if rsp_ch ();

    lru_handle_cache_with_staleness dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    // Shadow copy of the cache table and its register.
    logic        shadow_valid [N_ENTRIES];
    logic [31:0] shadow_key   [N_ENTRIES];
    logic [62:0] shadow_ver   [N_ENTRIES];
    logic [31:0] shadow_stamp [N_ENTRIES];
    logic [31:0] shadow_clock;
    logic        shadow_reuse;

    t_result     pending_lookups [$];
    logic [31:0] key_pool [POOL_SIZE];
    logic [62:0] ver_pool [POOL_SIZE];

    int error_count     = 0;
    int cycle_count     = 0;
    int rsp_hold_cycles = 0;
    int rsp_max_stall   = 13;
    int req_max_gap     = 13;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    function automatic logic [62:0] rand_version();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[62:0];
    endfunction

    function automatic t_result predict_lookup(input logic cmd, input logic [31:0] key,
                                               input logic [62:0] ver, input logic rok,
                                               input logic cok);
        t_result r;
        int      free_idx;
        int      lru_idx;
        int      hit_idx;
        int      target;
        logic    dropped;
        logic    stop;
        r        = '0;
        free_idx = -1;
        lru_idx  = -1;
        hit_idx  = -1;
        dropped  = 1'b0;
        stop     = 1'b0;
        if (cmd == CMD_FLUSH) begin
            for (int i = 0; i < N_ENTRIES; i++) shadow_valid[i] = 1'b0;
            r.status = STATUS_FLUSHED;
        end else if (!shadow_reuse) begin
            r.status = STATUS_UNCACHED;
        end else begin
            for (int i = 0; i < N_ENTRIES; i++) begin
                if (!stop) begin
                    if (!shadow_valid[i]) begin
                        if (free_idx < 0) free_idx = i;
                    end else if (shadow_key[i] == key) begin
                        stop = 1'b1;
                        if (shadow_ver[i] == ver && rok) begin
                            hit_idx = i;
                        end else begin
                            // stale or unresettable: drop, reuse its slot
                            shadow_valid[i] = 1'b0;
                            dropped         = 1'b1;
                            free_idx        = i;
                        end
                    end else if (lru_idx < 0 || shadow_stamp[i] < shadow_stamp[lru_idx]) begin
                        lru_idx = i;
                    end
                end
            end
            if (hit_idx >= 0) begin
                shadow_clock          = shadow_clock + 1;
                shadow_stamp[hit_idx] = shadow_clock;
                r.status              = STATUS_HIT;
                r.slot                = 4'(hit_idx);
            end else if (!cok) begin
                r.status        = STATUS_COMPILE_ERR;
                r.stale_dropped = dropped;
            end else begin
                if (free_idx >= 0) begin
                    target = free_idx;
                end else begin
                    target    = (lru_idx >= 0) ? lru_idx : 0;
                    r.evicted = 1'b1;
                end
                shadow_clock         = shadow_clock + 1;
                shadow_valid[target] = 1'b1;
                shadow_key[target]   = key;
                shadow_ver[target]   = ver;
                shadow_stamp[target] = shadow_clock;
                r.status             = STATUS_INSTALLED;
                r.slot               = 4'(target);
                r.stale_dropped      = dropped;
            end
        end
        return r;
    endfunction

    // Called at a rising edge; returns at the edge of the transfer with valid still high.
    task automatic send_item(input logic cmd, input logic [31:0] key, input logic [62:0] ver,
                             input logic rok, input logic cok);
        int gap;
        gap = $urandom_range(0, req_max_gap);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= cmd;
        req_ch.key        <= key;
        req_ch.version    <= ver;
        req_ch.reset_ok   <= rok;
        req_ch.compile_ok <= cok;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        pending_lookups.push_back(predict_lookup(cmd, key, ver, rok, cok));
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reuse(input logic value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_reuse = value;
    endtask

    task automatic random_item();
        int pick;
        int p;
        pick = $urandom_range(0, 99);
        p    = $urandom_range(0, POOL_SIZE - 1);
        if (pick < 2) begin
            send_item(CMD_FLUSH, $urandom, rand_version(), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        end else if (pick < 12) begin
            send_item(CMD_ACQUIRE, $urandom, rand_version(), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        end else begin
            // script changed on disk now and then
            if ($urandom_range(0, 9) == 0) ver_pool[p] = rand_version();
            send_item(CMD_ACQUIRE, key_pool[p], ver_pool[p], $urandom_range(0, 9) != 0,
                      $urandom_range(0, 9) != 0);
        end
    endtask

    task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    initial begin : response_checker
        t_result want;
        int      stall;
        wait (i_rst_n === 1'b1);
        forever begin
            if (rsp_hold_cycles > 0) begin
                stall           = rsp_hold_cycles;
                rsp_hold_cycles = 0;
            end else begin
                stall = $urandom_range(0, rsp_max_stall);
            end
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (rsp_ch.valid !== 1'b1);
            if (pending_lookups.size() == 0) begin
                error_count++;
                $display("%0t: unexpected transfer: expected none, actual status %0d slot %0d",
                         $time, rsp_ch.status, rsp_ch.slot);
            end else begin
                want = pending_lookups.pop_front();
                check_field("status", {1'b0, want.status}, {1'b0, rsp_ch.status});
                check_field("slot", want.slot, rsp_ch.slot);
                check_field("evicted", {3'b0, want.evicted}, {3'b0, rsp_ch.evicted});
                check_field("stale_dropped", {3'b0, want.stale_dropped},
                            {3'b0, rsp_ch.stale_dropped});
            end
        end
    end

    task automatic test_directed();
        send_item(CMD_FLUSH, 32'h0, 63'h0, 1'b0, 1'b0);                 // flush on empty table
        send_item(CMD_ACQUIRE, 32'h0, 63'h0, 1'b1, 1'b1);               // install slot 0
        send_item(CMD_ACQUIRE, 32'h0, 63'h0, 1'b1, 1'b1);               // hit
        send_item(CMD_ACQUIRE, 32'hFFFF_FFFF, VERSION_MAX, 1'b1, 1'b1);
        send_item(CMD_ACQUIRE, 32'hFFFF_FFFF, VERSION_MAX, 1'b1, 1'b1);
        send_item(CMD_ACQUIRE, 32'h0, 63'h1, 1'b1, 1'b1);               // stale version
        send_item(CMD_ACQUIRE, 32'h0, 63'h1, 1'b0, 1'b1);               // reset failed
        send_item(CMD_ACQUIRE, 32'h0, 63'h1, 1'b0, 1'b0);               // drop + compile fail
        send_item(CMD_ACQUIRE, 32'h0, 63'h1, 1'b1, 1'b0);               // plain compile fail
        send_item(CMD_ACQUIRE, 32'h5A5A_A5A5, {32'h2AAA_5555, 31'h5555_AAAA}, 1'b1, 1'b1);
        send_item(CMD_ACQUIRE, 32'hFFFF_FFFF, 63'h0, 1'b1, 1'b0);
        send_item(CMD_ACQUIRE, 32'h5A5A_A5A5, {32'h2AAA_5555, 31'h5555_AAAA}, 1'b1, 1'b1);
        send_item(CMD_FLUSH, 32'hFFFF_FFFF, VERSION_MAX, 1'b1, 1'b1);
    endtask

    task automatic test_eviction();
        for (int i = 0; i < N_ENTRIES; i++)
            send_item(CMD_ACQUIRE, 32'd100 + i, 63'(i), 1'b1, 1'b1);
        send_item(CMD_ACQUIRE, 32'd100, 63'd0, 1'b1, 1'b1);             // refresh slot 0
        send_item(CMD_ACQUIRE, 32'd200, 63'd7, 1'b1, 1'b1);             // evicts oldest
        send_item(CMD_ACQUIRE, 32'd201, 63'd7, 1'b1, 1'b1);
        send_item(CMD_ACQUIRE, 32'd105, 63'd99, 1'b1, 1'b1);            // full, but stale match
        send_item(CMD_FLUSH, 32'h0, 63'h0, 1'b0, 1'b0);
    endtask

    task automatic test_reuse_config();
        send_item(CMD_ACQUIRE, 32'd7, 63'd7, 1'b1, 1'b1);
        write_reuse(1'b0);
        send_item(CMD_ACQUIRE, 32'd7, 63'd7, 1'b1, 1'b1);
        send_item(CMD_ACQUIRE, 32'd8, 63'd8, 1'b1, 1'b0);
        send_item(CMD_FLUSH, 32'd0, 63'd0, 1'b1, 1'b1);                 // flush works when off
        write_reuse(1'b1);
        send_item(CMD_ACQUIRE, 32'd7, 63'd7, 1'b1, 1'b1);
        send_item(CMD_ACQUIRE, 32'd7, 63'd7, 1'b1, 1'b1);
    endtask

    task automatic test_backpressure();
        wait_idle();
        rsp_hold_cycles = 300;
        req_max_gap     = 0;
        repeat (30) random_item();
        req_max_gap = 13;
        wait_idle();                                                    // sender pause
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                1: begin
                    write_reuse(1'b0);
                    repeat (30) random_item();
                    write_reuse(1'b1);
                end
                3: begin
                    // back to back on both sides
                    req_max_gap   = 0;
                    rsp_max_stall = 0;
                    repeat (100) random_item();
                    req_max_gap   = 13;
                    rsp_max_stall = 13;
                end
                default: begin
                    repeat (100) random_item();
                    wait_idle();
                end
            endcase
        end
        write_reuse(1'b1);
        repeat (50) random_item();
    endtask

    initial begin : main_sequence
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.cmd        = CMD_ACQUIRE;
        req_ch.key        = '0;
        req_ch.version    = '0;
        req_ch.reset_ok   = 1'b0;
        req_ch.compile_ok = 1'b0;
        rsp_ch.ready      = 1'b0;
        for (int i = 0; i < N_ENTRIES; i++) shadow_valid[i] = 1'b0;
        shadow_clock = '0;
        shadow_reuse = 1'b1;
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
            ver_pool[i] = rand_version();
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_eviction();
        test_reuse_config();
        test_backpressure();
        test_random();
        wait_idle();

        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/lhc_pkg.sv
hdl/lhc_req_if.sv
hdl/lhc_rsp_if.sv
hdl/lhc_store.sv
hdl/lhc_ctrl.sv
hdl/lru_handle_cache_with_staleness.sv
bench/testbench.sv
